@@ sv/jfc_pkg.sv @@
// ----------------------------------------------------------------------------
// jfc_pkg : shared constants for the Jakes fading channel
// Widths, polynomial coefficients, scale and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package jfc_pkg;

    localparam int OSCILLATORS = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 18;
    localparam int ANGLE_W     = 16;
    localparam int TRIG_W      = 16;
    localparam int Z_W         = 17;
    localparam int COS_LAT     = 8;
    localparam int HORNER      = 4;

    localparam logic [31:0] POLY_C9 = 32'd172272;
    localparam logic [31:0] POLY_C [HORNER] = '{
        32'd5026995, 32'd85569306, 32'd693598669, 32'd1686629713
    };

    localparam int OSC_W   = (OSCILLATORS > 1) ? $clog2(OSCILLATORS) : 1;
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int SUM_W   = 30 + OSC_W;
    localparam int SCALE_W = 16;

    function automatic logic [63:0] isqrt_c(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = v;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    localparam logic [SCALE_W-1:0] SCALE =
        SCALE_W'(isqrt_c((64'd2 << 28) / OSCILLATORS));

    localparam int ALPHA_DIV     = 4 * OSCILLATORS;
    localparam int ALPHA_NUM_W   = 20;
    localparam int ALPHA_SH      = 26;
    localparam int ALPHA_RECIP_W = 27;
    localparam logic [ALPHA_RECIP_W-1:0] ALPHA_RECIP =
        ALPHA_RECIP_W'(((64'd1 << ALPHA_SH) + ALPHA_DIV - 1) / ALPHA_DIV);

    localparam int SQ_PER   = 3;
    localparam int SQ_STG   = (GAIN_BITS + SQ_PER - 1) / SQ_PER;
    localparam int SQ_RAD_W = 2 * GAIN_BITS;
    localparam int SQ_REM_W = GAIN_BITS + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_DOPPLER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THETA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAT_LO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAT_HI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE  = 3'd5;

    localparam logic [31:0] DOPPLER_RST = 32'd2147;

endpackage

`default_nettype wire

@@ sv/jakes_fading_channel.sv @@
// ----------------------------------------------------------------------------
// jakes_fading_channel : sum-of-sinusoids Rayleigh fading on a sample stream
// Builds the fading coefficient from parallel oscillators and applies it
// by complex multiply or by magnitude scaling, with saturation.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// sample    in         i_valid / o_ready          sample_real, sample_imag, index
// faded     out        o_valid / i_ready          faded_*, gain_*
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request per clock while the skid is empty and no table rebuild runs; the
// result passes the eight-stage cosine units and the six-stage square root. A
// two-entry output (last stage plus skid) keeps input flowing while a result
// waits. After reset and after a write of doppler_step, arrival_offset or a
// scatter word, the rate and scatter tables are rebuilt through one cosine
// unit; input is held off meanwhile. A full skid stalls the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module jakes_fading_channel (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [jfc_pkg::SAMPLE_BITS-1:0]  i_sample_real,
    input  logic signed [jfc_pkg::SAMPLE_BITS-1:0]  i_sample_imag,
    input  logic [30:0]                             i_sample_index,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [jfc_pkg::SAMPLE_BITS-1:0]  o_faded_real,
    output logic signed [jfc_pkg::SAMPLE_BITS-1:0]  o_faded_imag,
    output logic signed [jfc_pkg::GAIN_BITS-1:0]    o_gain_real,
    output logic signed [jfc_pkg::GAIN_BITS-1:0]    o_gain_imag,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [jfc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [jfc_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import jfc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int GB    = GAIN_BITS;
    localparam int OPD_W = GB + 1;
    localparam int XP_W  = SB + OPD_W;
    localparam int MSC_W = SUM_W + SCALE_W;
    localparam int N_STG = COS_LAT + SQ_STG + 8;

    localparam logic [1:0] SEQ_ALPHA = 2'd0;
    localparam logic [1:0] SEQ_COS   = 2'd1;
    localparam logic [1:0] SEQ_SIN   = 2'd2;

    typedef struct packed {
        logic signed [SB-1:0] sr;
        logic signed [SB-1:0] si;
        logic signed [GB-1:0] gr;
        logic signed [GB-1:0] gi;
    } t_side;

    typedef struct packed {
        logic             vld;
        logic [1:0]       grp;
        logic [OSC_W-1:0] osc;
    } t_tag;

    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v, input int sh);
        logic signed [63:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [63:0] f_sat(input logic signed [63:0] v, input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // configuration
    logic [31:0] r_doppler;
    logic [15:0] r_common;
    logic [15:0] r_theta;
    logic [63:0] r_scat_lo;
    logic [63:0] r_scat_hi;
    logic        r_rotate;
    logic        w_trig;
    logic [127:0] w_psi_all;

    // table sequencer
    logic             r_iss_act;
    logic [1:0]       r_iss_grp;
    logic [OSC_W-1:0] r_iss_osc;
    t_tag             r_tag [COS_LAT];
    t_tag             w_cap;
    logic             w_busy;
    logic [ALPHA_NUM_W-1:0] w_num;
    logic [ALPHA_NUM_W+ALPHA_RECIP_W-1:0] w_quo;
    logic [15:0]      w_psi;
    logic [ANGLE_W-1:0] w_seq_ang;
    logic signed [TRIG_W-1:0] w_seq_cos;
    logic [TRIG_W-1:0] w_mag;
    logic [47:0]      w_rprod;
    logic [31:0]      w_rabs;
    logic [31:0]      w_rate;

    logic [31:0]              r_rate [OSCILLATORS];
    logic signed [TRIG_W-1:0] r_cpsi [OSCILLATORS];
    logic signed [TRIG_W-1:0] r_spsi [OSCILLATORS];

    // datapath
    logic                     w_en;
    logic                     w_in_acc;
    logic [N_STG-1:0]         r_vld;
    logic [ANGLE_W-1:0]       n_ang  [OSCILLATORS];
    logic [ANGLE_W-1:0]       r_a_ang [OSCILLATORS];
    logic signed [SB-1:0]     r_a_sr, r_a_si;
    logic signed [SB-1:0]     r_dl_sr [COS_LAT];
    logic signed [SB-1:0]     r_dl_si [COS_LAT];
    logic signed [TRIG_W-1:0] w_osc  [OSCILLATORS];
    logic signed [PROD_W-1:0] r_p_re [OSCILLATORS];
    logic signed [PROD_W-1:0] r_p_im [OSCILLATORS];
    logic signed [SB-1:0]     r_p_sr, r_p_si;
    logic signed [SUM_W-1:0]  n_s_re, n_s_im, r_s_re, r_s_im;
    logic signed [SB-1:0]     r_s_sr, r_s_si;
    logic signed [MSC_W-1:0]  r_m_re, r_m_im;
    logic signed [SB-1:0]     r_m_sr, r_m_si;
    logic signed [GB-1:0]     r_g_re, r_g_im;
    logic signed [SB-1:0]     r_g_sr, r_g_si;
    logic signed [SQ_RAD_W:0] w_sqsum;

    logic [SQ_RAD_W-1:0]      r_sq_rad  [SQ_STG+1];
    logic [SQ_REM_W-1:0]      r_sq_rem  [SQ_STG+1];
    logic [GB-1:0]            r_sq_root [SQ_STG+1];
    t_side                    r_sq_sd   [SQ_STG+1];
    logic [SQ_REM_W-1:0]      n_sq_rem  [1:SQ_STG];
    logic [GB-1:0]            n_sq_root [1:SQ_STG];

    t_side                    w_xs;
    logic signed [OPD_W-1:0]  w_x1, w_x2, w_x3, w_x4;
    logic signed [XP_W-1:0]   r_x_a, r_x_b, r_x_c, r_x_d;
    logic signed [GB-1:0]     r_x_gr, r_x_gi;

    logic signed [SB-1:0]     r_f_fr, r_f_fi;
    logic signed [GB-1:0]     r_f_gr, r_f_gi;
    logic                     r_skid_v;
    logic signed [SB-1:0]     r_skid_fr, r_skid_fi;
    logic signed [GB-1:0]     r_skid_gr, r_skid_gi;

    assign o_cfg_ready = 1'b1;
    assign w_trig = i_cfg_valid && (i_cfg_index == CFG_DOPPLER || i_cfg_index == CFG_THETA ||
                    i_cfg_index == CFG_SCAT_LO || i_cfg_index == CFG_SCAT_HI);
    assign w_psi_all = {r_scat_hi, r_scat_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doppler <= DOPPLER_RST;
            r_common  <= '0;
            r_theta   <= '0;
            r_scat_lo <= '0;
            r_scat_hi <= '0;
            r_rotate  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DOPPLER: r_doppler <= i_cfg_data[31:0];
                CFG_COMMON:  r_common  <= i_cfg_data[15:0];
                CFG_THETA:   r_theta   <= i_cfg_data[15:0];
                CFG_SCAT_LO: r_scat_lo <= i_cfg_data;
                CFG_SCAT_HI: r_scat_hi <= i_cfg_data;
                CFG_ROTATE:  r_rotate  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // table sequencer: alpha cosines, scatter cosines, scatter sines
    always_comb begin
        w_num = {4'(r_iss_osc) + 4'd1, 16'h0000} - ALPHA_NUM_W'(32768) + ALPHA_NUM_W'(r_theta);
        w_quo = (ALPHA_NUM_W+ALPHA_RECIP_W)'(w_num) * (ALPHA_NUM_W+ALPHA_RECIP_W)'(ALPHA_RECIP);
        w_psi = w_psi_all[16*r_iss_osc +: 16];
        case (r_iss_grp)
            SEQ_ALPHA: w_seq_ang = w_quo[ALPHA_SH +: ANGLE_W];
            SEQ_COS:   w_seq_ang = w_psi;
            default:   w_seq_ang = w_psi - 16'h4000;
        endcase
    end

    jfc_cos u_seq_cos (
        .i_clk   (i_clk),
        .i_en    (1'b1),
        .i_angle (w_seq_ang),
        .o_cos   (w_seq_cos)
    );

    always_comb begin
        w_busy = r_iss_act;
        for (int i = 0; i < COS_LAT; i++) begin
            w_busy = w_busy | r_tag[i].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_act <= 1'b1;
            r_iss_grp <= SEQ_ALPHA;
            r_iss_osc <= '0;
            for (int i = 0; i < COS_LAT; i++) begin
                r_tag[i] <= '0;
            end
        end else begin
            r_tag[0] <= '{vld: r_iss_act, grp: r_iss_grp, osc: r_iss_osc};
            for (int i = 1; i < COS_LAT; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            if (w_trig) begin
                r_iss_act <= 1'b1;
                r_iss_grp <= SEQ_ALPHA;
                r_iss_osc <= '0;
            end else if (r_iss_act) begin
                if (r_iss_osc == OSC_W'(OSCILLATORS - 1)) begin
                    r_iss_osc <= '0;
                    if (r_iss_grp == SEQ_SIN) begin
                        r_iss_act <= 1'b0;
                    end else begin
                        r_iss_grp <= r_iss_grp + 2'd1;
                    end
                end else begin
                    r_iss_osc <= r_iss_osc + OSC_W'(1);
                end
            end
        end
    end

    assign w_cap   = r_tag[COS_LAT-1];
    assign w_mag   = w_seq_cos[TRIG_W-1] ? TRIG_W'(-w_seq_cos) : TRIG_W'(w_seq_cos);
    assign w_rprod = 48'(r_doppler) * 48'(w_mag) + 48'd8192;
    assign w_rabs  = w_rprod[45:14];
    assign w_rate  = w_seq_cos[TRIG_W-1] ? (32'd0 - w_rabs) : w_rabs;

    always_ff @(posedge i_clk) begin
        if (w_cap.vld) begin
            unique case (w_cap.grp)
                SEQ_ALPHA: r_rate[w_cap.osc] <= w_rate;
                SEQ_COS:   r_cpsi[w_cap.osc] <= w_seq_cos;
                SEQ_SIN:   r_spsi[w_cap.osc] <= w_seq_cos;
                default: ;
            endcase
        end
    end

    // request pipeline
    assign w_en     = !r_skid_v;
    assign o_ready  = w_en && !w_busy;
    assign w_in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STG-2:0], w_in_acc};
        end
    end

    always_comb begin : phase
        logic [31:0] ph;
        for (int k = 0; k < OSCILLATORS; k++) begin
            ph = 32'({1'b0, i_sample_index} * r_rate[k]) + {r_common, 16'h0000};
            n_ang[k] = ph[31:16];
        end
    end

    for (genvar k = 0; k < OSCILLATORS; k++) begin : g_osc
        jfc_cos u_cos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (r_a_ang[k]),
            .o_cos   (w_osc[k])
        );
    end

    always_comb begin
        n_s_re = '0;
        n_s_im = '0;
        for (int k = 0; k < OSCILLATORS; k++) begin
            n_s_re = n_s_re + SUM_W'(r_p_re[k]);
            n_s_im = n_s_im + SUM_W'(r_p_im[k]);
        end
    end

    assign w_sqsum = (SQ_RAD_W+1)'(r_g_re) * (SQ_RAD_W+1)'(r_g_re)
                   + (SQ_RAD_W+1)'(r_g_im) * (SQ_RAD_W+1)'(r_g_im);

    always_comb begin : sqrt_stages
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_REM_W-1:0] trial;
        logic [GB-1:0]       root;
        int                  d;
        for (int s = 0; s < SQ_STG; s++) begin
            rem  = r_sq_rem[s];
            root = r_sq_root[s];
            for (int j = 0; j < SQ_PER; j++) begin
                d = GB - 1 - (s * SQ_PER + j);
                if (d >= 0) begin
                    rem   = {rem[SQ_REM_W-3:0], r_sq_rad[s][2*d +: 2]};
                    trial = SQ_REM_W'({root, 2'b01});
                    if (rem >= trial) begin
                        rem  = rem - trial;
                        root = {root[GB-2:0], 1'b1};
                    end else begin
                        root = {root[GB-2:0], 1'b0};
                    end
                end
            end
            n_sq_rem[s+1]  = rem;
            n_sq_root[s+1] = root;
        end
    end

    always_comb begin
        w_xs = r_sq_sd[SQ_STG];
        if (r_rotate) begin
            w_x1 = OPD_W'(w_xs.gr);
            w_x2 = OPD_W'(w_xs.gi);
            w_x3 = OPD_W'(w_xs.gi);
            w_x4 = OPD_W'(w_xs.gr);
        end else begin
            w_x1 = $signed({1'b0, r_sq_root[SQ_STG]});
            w_x2 = '0;
            w_x3 = '0;
            w_x4 = $signed({1'b0, r_sq_root[SQ_STG]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < OSCILLATORS; k++) begin
                r_a_ang[k] <= n_ang[k];
            end
            r_a_sr <= i_sample_real;
            r_a_si <= i_sample_imag;
            r_dl_sr[0] <= r_a_sr;
            r_dl_si[0] <= r_a_si;
            for (int i = 1; i < COS_LAT; i++) begin
                r_dl_sr[i] <= r_dl_sr[i-1];
                r_dl_si[i] <= r_dl_si[i-1];
            end
            for (int k = 0; k < OSCILLATORS; k++) begin
                r_p_re[k] <= PROD_W'(r_cpsi[k]) * PROD_W'(w_osc[k]);
                r_p_im[k] <= PROD_W'(r_spsi[k]) * PROD_W'(w_osc[k]);
            end
            r_p_sr <= r_dl_sr[COS_LAT-1];
            r_p_si <= r_dl_si[COS_LAT-1];
            r_s_re <= n_s_re;
            r_s_im <= n_s_im;
            r_s_sr <= r_p_sr;
            r_s_si <= r_p_si;
            r_m_re <= MSC_W'(r_s_re) * MSC_W'($signed({1'b0, SCALE}));
            r_m_im <= MSC_W'(r_s_im) * MSC_W'($signed({1'b0, SCALE}));
            r_m_sr <= r_s_sr;
            r_m_si <= r_s_si;
            r_g_re <= GB'(f_sat(f_rnd(64'(r_m_re), 28), GB));
            r_g_im <= GB'(f_sat(f_rnd(64'(r_m_im), 28), GB));
            r_g_sr <= r_m_sr;
            r_g_si <= r_m_si;
            r_sq_rad[0]  <= w_sqsum[SQ_RAD_W-1:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_sd[0]   <= '{sr: r_g_sr, si: r_g_si, gr: r_g_re, gi: r_g_im};
            for (int s = 1; s <= SQ_STG; s++) begin
                r_sq_rad[s]  <= r_sq_rad[s-1];
                r_sq_rem[s]  <= n_sq_rem[s];
                r_sq_root[s] <= n_sq_root[s];
                r_sq_sd[s]   <= r_sq_sd[s-1];
            end
            r_x_a  <= XP_W'(w_xs.sr) * XP_W'(w_x1);
            r_x_b  <= XP_W'(w_xs.si) * XP_W'(w_x2);
            r_x_c  <= XP_W'(w_xs.sr) * XP_W'(w_x3);
            r_x_d  <= XP_W'(w_xs.si) * XP_W'(w_x4);
            r_x_gr <= w_xs.gr;
            r_x_gi <= w_xs.gi;
            r_f_fr <= SB'(f_sat(f_rnd(64'(r_x_a) - 64'(r_x_b), 14), SB));
            r_f_fi <= SB'(f_sat(f_rnd(64'(r_x_c) + 64'(r_x_d), 14), SB));
            r_f_gr <= r_x_gr;
            r_f_gi <= r_x_gi;
        end
    end

    // output skid: hold a result that was not taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_vld[N_STG-1] && !i_ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_fr <= r_f_fr;
            r_skid_fi <= r_f_fi;
            r_skid_gr <= r_f_gr;
            r_skid_gi <= r_f_gi;
        end
    end

    assign o_valid      = r_skid_v | r_vld[N_STG-1];
    assign o_faded_real = r_skid_v ? r_skid_fr : r_f_fr;
    assign o_faded_imag = r_skid_v ? r_skid_fi : r_f_fi;
    assign o_gain_real  = r_skid_v ? r_skid_gr : r_f_gr;
    assign o_gain_imag  = r_skid_v ? r_skid_gi : r_f_gi;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_ready) |=> (r_skid_v && $stable(r_skid_fr) && $stable(r_skid_gr)))
        else $error("skid entry lost or changed while output stalled");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && w_busy))
        else $error("reset did not clear output or start table rebuild");

endmodule

`default_nettype wire

@@ sv/jfc_cos.sv @@
// ----------------------------------------------------------------------------
// jfc_cos : pipelined cosine of a 16-bit turn angle
// Quarter-wave fold, ninth-order odd polynomial in Q30, Q14 rounded result.
// ----------------------------------------------------------------------------
`default_nettype none

module jfc_cos (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [jfc_pkg::ANGLE_W-1:0]         i_angle,
    output logic signed [jfc_pkg::TRIG_W-1:0]   o_cos
);
    import jfc_pkg::*;

    logic [1:0]     w_q;
    logic [13:0]    w_r;
    logic [Z_W-1:0] n_z;
    logic           n_neg;

    logic [Z_W-1:0] r_z1;
    logic           r_n1;
    logic [31:0]    r_hz2  [HORNER+1];
    logic [Z_W-1:0] r_hz   [HORNER+1];
    logic           r_hn   [HORNER+1];
    logic [31:0]    r_hacc [1:HORNER];
    logic [31:0]    n_hacc [1:HORNER];
    logic [31:0]    r_mz;
    logic           r_n7;
    logic [32:0]    w_rnd;

    assign w_q = i_angle[15:14];
    assign w_r = i_angle[13:0];

    always_comb begin
        if (w_q == 2'd0 || w_q == 2'd2) begin
            n_z = {15'h4000 - {1'b0, w_r}, 2'b00};
        end else begin
            n_z = {1'b0, w_r, 2'b00};
        end
        n_neg = (w_q == 2'd1 || w_q == 2'd2);
    end

    always_comb begin : horner
        logic [63:0] prod;
        logic [31:0] acc;
        for (int i = 1; i <= HORNER; i++) begin
            acc       = (i == 1) ? POLY_C9 : r_hacc[(i == 1) ? 1 : i-1];
            prod      = 64'(acc) * 64'(r_hz2[i-1]);
            n_hacc[i] = POLY_C[i-1] - 32'(prod >> 30);
        end
    end

    assign w_rnd = (33'(r_mz) + 33'd32768) >> 16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1 <= n_z;
            r_n1 <= n_neg;
            r_hz2[0] <= 32'((34'(r_z1) * 34'(r_z1)) >> 2);
            r_hz[0]  <= r_z1;
            r_hn[0]  <= r_n1;
            for (int i = 1; i <= HORNER; i++) begin
                r_hacc[i] <= n_hacc[i];
                r_hz2[i]  <= r_hz2[i-1];
                r_hz[i]   <= r_hz[i-1];
                r_hn[i]   <= r_hn[i-1];
            end
            r_mz  <= 32'((64'(r_hacc[HORNER]) * 64'(r_hz[HORNER])) >> 16);
            r_n7  <= r_hn[HORNER];
            o_cos <= r_n7 ? -TRIG_W'(w_rnd) : TRIG_W'(w_rnd);
        end
    end

endmodule

`default_nettype wire

@@ tb/jakes_fading_channel_test.sv @@
// ----------------------------------------------------------------------------
// jakes_fading_channel_test : self-checking bench for the Jakes fading channel
// Drives samples and register writes over valid/ready channels, predicts the
// coefficient and the faded sample in fixed point, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class fade_scoreboard;
    logic [31:0] dstep;
    logic [15:0] cphase;
    logic [15:0] theta;
    logic [63:0] psi_lo;
    logic [63:0] psi_hi;
    logic        rot;
    logic [31:0] rates [8];
    logic [67:0] pending [$];
    int          errors;
    int          checked;

    function new();
        errors  = 0;
        checked = 0;
        dstep   = jfc_pkg::DOPPLER_RST;
        cphase  = 0;
        theta   = 0;
        psi_lo  = 0;
        psi_hi  = 0;
        rot     = 1;
        build_rates();
    endfunction

    function automatic longint sin_q(longint unsigned z);
        longint unsigned z2, acc;
        z2  = (z * z) >> 2;
        acc = 172272;
        acc = 5026995 - ((acc * z2) >> 30);
        acc = 85569306 - ((acc * z2) >> 30);
        acc = 693598669 - ((acc * z2) >> 30);
        acc = 1686629713 - ((acc * z2) >> 30);
        acc = (acc * z) >> 16;
        return longint'((acc + 32768) >> 16);
    endfunction

    function automatic longint cos_t(logic [15:0] a);
        longint unsigned r;
        r = a[13:0];
        case (a[15:14])
            2'd0: return sin_q((16384 - r) << 2);
            2'd1: return -sin_q(r << 2);
            2'd2: return -sin_q((16384 - r) << 2);
            default: return sin_q(r << 2);
        endcase
    endfunction

    function automatic longint unsigned root(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint rshift(longint v, int sh);
        longint unsigned m;
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function void build_rates();
        longint num, c;
        longint unsigned r;
        for (int k = 0; k < 8; k++) begin
            num = (k + 1) * 65536 - 32768 + longint'(theta);
            c   = cos_t(16'(num / 32));
            r   = ((longint'(dstep) * (c < 0 ? -c : c)) + 8192) >> 14;
            rates[k] = c < 0 ? 32'(-r) : 32'(r);
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
        case (idx)
            jfc_pkg::CFG_DOPPLER: begin dstep = v[31:0]; build_rates(); end
            jfc_pkg::CFG_COMMON:  cphase = v[15:0];
            jfc_pkg::CFG_THETA:   begin theta = v[15:0]; build_rates(); end
            jfc_pkg::CFG_SCAT_LO: psi_lo = v;
            jfc_pkg::CFG_SCAT_HI: psi_hi = v;
            jfc_pkg::CFG_ROTATE:  rot = v[0];
            default: ;
        endcase
    endfunction

    function void note_sample(logic signed [15:0] sr, logic signed [15:0] si,
                              logic [30:0] idx);
        longint sre, sim, gr, gi, fr, fi, m, osc;
        logic [31:0] ph;
        logic [15:0] psi;
        sre = 0;
        sim = 0;
        for (int k = 0; k < 8; k++) begin
            ph  = 32'(longint'(idx) * longint'(rates[k])) + {cphase, 16'd0};
            osc = cos_t(ph[31:16]);
            psi = k < 4 ? psi_lo[16*k +: 16] : psi_hi[16*(k-4) +: 16];
            sre += cos_t(psi) * osc;
            sim += cos_t(psi - 16'h4000) * osc;
        end
        m  = root((64'd2 << 28) / 8);
        gr = clamp(rshift(sre * m, 28), 18);
        gi = clamp(rshift(sim * m, 28), 18);
        if (rot) begin
            fr = rshift(sr * gr - si * gi, 14);
            fi = rshift(sr * gi + si * gr, 14);
        end else begin
            m  = root(gr * gr + gi * gi);
            fr = rshift(sr * m, 14);
            fi = rshift(si * m, 14);
        end
        pending.push_back({16'(clamp(fr, 16)), 16'(clamp(fi, 16)), 18'(gr), 18'(gi)});
    endfunction

    function void check_result(logic [15:0] fr, logic [15:0] fi,
                               logic [17:0] gr, logic [17:0] gi);
        logic [67:0] want, got;
        got = {fr, fi, gr, gi};
        checked++;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: %h", $time, got);
            return;
        end
        want = pending.pop_front();
        if (want[67:52] !== fr) begin
            errors++;
            $display("%0t: faded_real exp %h got %h", $time, want[67:52], fr);
        end
        if (want[51:36] !== fi) begin
            errors++;
            $display("%0t: faded_imag exp %h got %h", $time, want[51:36], fi);
        end
        if (want[35:18] !== gr) begin
            errors++;
            $display("%0t: gain_real exp %h got %h", $time, want[35:18], gr);
        end
        if (want[17:0] !== gi) begin
            errors++;
            $display("%0t: gain_imag exp %h got %h", $time, want[17:0], gi);
        end
    endfunction
endclass

module jakes_fading_channel_test;
    import jfc_pkg::*;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample_real;
    logic signed [SAMPLE_BITS-1:0] i_sample_imag;
    logic [30:0]                   i_sample_index;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [SAMPLE_BITS-1:0] o_faded_real;
    logic signed [SAMPLE_BITS-1:0] o_faded_imag;
    logic signed [GAIN_BITS-1:0]   o_gain_real;
    logic signed [GAIN_BITS-1:0]   o_gain_imag;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;

    fade_scoreboard sb;
    int             send_idle;
    int             recv_idle;
    int             samples_sent;
    longint         cycle_count;

    jakes_fading_channel i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("** jakes_fading_channel: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_faded_real, o_faded_imag, o_gain_real, o_gain_imag);
        i_ready <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_sample(logic [15:0] sr, logic [15:0] si, logic [30:0] idx);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid        <= 1;
        i_sample_real  <= sr;
        i_sample_imag  <= si;
        i_sample_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(sr, si, idx);
        samples_sent++;
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        drain();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, v);
        i_cfg_valid <= 0;
    endtask

    task automatic random_samples(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send_sample($urandom_range(1) ? 16'h8000 : 16'h7fff, 16'($urandom),
                            $urandom_range(1) ? 31'h7fffffff : 31'($urandom));
            else
                send_sample(16'($urandom), 16'($urandom), 31'($urandom));
            if (i == n / 2) drain();
        end
    endtask

    task automatic random_config();
        write_reg(CFG_DOPPLER, $urandom_range(3) == 0 ? 64'($urandom)
                                                      : 64'($urandom_range(200000)));
        write_reg(CFG_COMMON, 64'($urandom));
        write_reg(CFG_THETA, 64'($urandom));
        write_reg(CFG_SCAT_LO, {$urandom, $urandom});
        write_reg(CFG_SCAT_HI, {$urandom, $urandom});
        write_reg(CFG_ROTATE, 64'($urandom_range(1)));
    endtask

    initial begin
        sb             = new();
        cycle_count    = 0;
        samples_sent   = 0;
        send_idle      = 0;
        recv_idle      = 0;
        i_rst_n        = 0;
        i_valid        = 0;
        i_ready        = 0;
        i_sample_real  = 0;
        i_sample_imag  = 0;
        i_sample_index = 0;
        i_cfg_valid    = 0;
        i_cfg_index    = 0;
        i_cfg_data     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_sample(16'h7fff, 16'h7fff, 31'd0);
        send_sample(16'h8000, 16'h8000, 31'h7fffffff);
        send_sample(16'h7fff, 16'h8000, 31'd1);
        send_sample(16'h0000, 16'h0000, 31'd12345);
        write_reg(CFG_SCAT_LO, 64'h0000_0000_0000_0000);
        write_reg(CFG_SCAT_HI, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_DOPPLER, 64'hffff_ffff);
        write_reg(CFG_THETA, 64'hffff);
        write_reg(CFG_COMMON, 64'hffff);
        send_sample(16'h7fff, 16'h7fff, 31'h7fffffff);
        send_sample(16'h8000, 16'h7fff, 31'd3);
        write_reg(CFG_ROTATE, 64'd0);
        send_sample(16'h7fff, 16'h8000, 31'h7fffffff);
        send_sample(16'h8000, 16'h8000, 31'd7);
        write_reg(3'd6, 64'hdead);
        write_reg(3'd7, 64'hbeef);
        write_reg(CFG_ROTATE, 64'hfffe);
        send_sample(16'h4000, 16'hc000, 31'd99);
        write_reg(CFG_ROTATE, 64'd1);
        write_reg(CFG_DOPPLER, 64'd0);
        write_reg(CFG_SCAT_LO, 64'h4000_4000_4000_4000);
        write_reg(CFG_SCAT_HI, 64'h4000_4000_4000_4000);
        send_sample(16'h7fff, 16'h7fff, 31'd5);
        send_sample(16'h8000, 16'h8000, 31'd6);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = ph == 0 ? 17 : (ph == 1 ? 79 : 0);
            recv_idle = ph == 0 ? 79 : (ph == 1 ? 17 : 0);
            for (int c = 0; c < 3; c++) begin
                random_config();
                random_samples(120);
            end
        end
        drain();
        $display("Sent %0d samples through %0d checked results,", samples_sent, sb.checked);
        $display("over random registers, both modes and three idling patterns.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** jakes_fading_channel: PASSED **");
        else
            $display("** jakes_fading_channel: FAILED **");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/jfc_pkg.sv
sv/jfc_cos.sv
sv/jakes_fading_channel.sv
tb/jakes_fading_channel_test.sv
